@@ sv/dfs_adjacency_matrix_walk_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the depth-first walk block
// Implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DFS_ADJACENCY_MATRIX_WALK_TOP_MACROS_SVH
`define DFS_ADJACENCY_MATRIX_WALK_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define DFSAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfsam: same-cycle check failed");

// next-cycle implication, disabled in reset
`define DFSAM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfsam: next-cycle check failed");

`endif

@@ sv/dfsam_pkg.sv @@
// ----------------------------------------------------------------------------
// dfsam_pkg
// Types and constants shared by the depth-first walk block.
// ----------------------------------------------------------------------------
`default_nettype none

package dfsam_pkg;

    localparam int NODES      = 16;
    localparam int RESULT_CAP = 16;
    localparam int NODE_W     = $clog2(NODES);
    localparam int LVL_W      = $clog2(NODES + 1);
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);
    localparam int FIELD_W    = 4;
    localparam int ROW_W      = 16;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] row_index;
        logic [ROW_W-1:0]   row_bits;
        logic [FIELD_W-1:0] start_node;
    } in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] node;
        logic [FIELD_W-1:0] depth;
        logic               last;
    } out_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        logic [NODES-1:0]  bits;
    } adj_wr_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } walk_state_t;

endpackage

`default_nettype wire

@@ sv/dfsam_pick.sv @@
// ----------------------------------------------------------------------------
// dfsam_pick
// Priority pick: lowest set bit of the unvisited-neighbour vector.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsam_pick (
    input  logic [dfsam_pkg::NODES-1:0]  cand,
    output logic                         found,
    output logic [dfsam_pkg::NODE_W-1:0] idx
);
    import dfsam_pkg::*;

    logic [NODES-1:0] lowest;

    assign found  = |cand;
    assign lowest = cand & (~cand + NODES'(1));

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | NODE_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/dfsam_adj.sv @@
// ----------------------------------------------------------------------------
// dfsam_adj
// Adjacency matrix: one row written per load beat, one row read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsam_adj (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dfsam_pkg::adj_wr_t           wr,
    input  logic [dfsam_pkg::NODE_W-1:0] rd_addr,
    output logic [dfsam_pkg::NODES-1:0]  rd_row
);
    import dfsam_pkg::*;

    logic [NODES-1:0] rows_reg [NODES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            rows_reg[wr.addr] <= wr.bits;
        end
    end

    assign rd_row = rows_reg[rd_addr];

endmodule

`default_nettype wire

@@ sv/dfsam_seq.sv @@
// ----------------------------------------------------------------------------
// dfsam_seq
// Walk sequencer: node stack, visited flags, one push or pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsam_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [dfsam_pkg::NODE_W-1:0] go_node,
    input  logic [dfsam_pkg::NODES-1:0]  adj_row,
    output logic [dfsam_pkg::NODE_W-1:0] top_node,
    output logic                         busy,
    output logic                         strobe,
    output dfsam_pkg::out_t              result
);
    import dfsam_pkg::*;

    walk_state_t        state_reg, state_next;
    logic [NODES-1:0]   seen_reg;
    logic [LVL_W-1:0]   level_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NODE_W-1:0]  pend_node_reg;
    logic [FIELD_W-1:0] pend_depth_reg;
    logic [NODE_W-1:0]  stack_reg [NODES];
    out_t               res_reg, res_next;
    logic               strobe_reg, strobe_next;

    logic [LVL_W-1:0]   level_m1;
    logic [NODES-1:0]   cand;
    logic               found;
    logic [NODE_W-1:0]  pick_idx;
    logic               finish;
    logic               do_push;
    logic               do_pop;

    assign level_m1 = level_reg - LVL_W'(1);
    assign top_node = stack_reg[level_m1[NODE_W-1:0]];
    assign cand     = adj_row & ~seen_reg;

    dfsam_pick u_pick (
        .cand  (cand),
        .found (found),
        .idx   (pick_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        finish      = 1'b0;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        strobe_next = 1'b0;
        res_next    = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                finish = 1'b0;
            end
            ST_WALK:
            begin
                finish  = (level_reg == '0) || (cnt_reg == CNT_W'(RESULT_CAP));
                do_push = !finish && found;
                do_pop  = !finish && !found;
                if (finish || do_push)
                begin
                    strobe_next    = 1'b1;
                    res_next.node  = FIELD_W'(pend_node_reg);
                    res_next.depth = pend_depth_reg;
                    res_next.last  = finish;
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seen_reg   <= '0;
            level_reg  <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            if (go)
            begin
                seen_reg  <= NODES'(1) << go_node;
                level_reg <= LVL_W'(1);
                cnt_reg   <= CNT_W'(1);
            end
            else if (finish)
            begin
                level_reg <= '0;
            end
            else if (do_pop)
            begin
                level_reg <= level_m1;
            end
            else if (do_push)
            begin
                seen_reg <= seen_reg | (NODES'(1) << pick_idx);
                cnt_reg  <= cnt_reg + CNT_W'(1);
                if (level_reg < LVL_W'(NODES))
                begin
                    level_reg <= level_reg + LVL_W'(1);
                end
            end
        end
    end

    // payload: stack, pending visit and result beat
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (go)
        begin
            stack_reg[0]   <= go_node;
            pend_node_reg  <= go_node;
            pend_depth_reg <= '0;
        end
        else if (do_push)
        begin
            pend_node_reg  <= pick_idx;
            pend_depth_reg <= FIELD_W'(level_reg);
            if (level_reg < LVL_W'(NODES))
            begin
                stack_reg[level_reg[NODE_W-1:0]] <= pick_idx;
            end
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

@@ sv/dfs_adjacency_matrix_walk_top.sv @@
// Load beat: writes one matrix row, no result; the next beat may follow at once.
// Run beat: first result is the start node at depth 0 (last set if it has no neighbour).
// Busy while the walk runs: the priority pick makes one stack push or pop
// per cycle, one result per push.
// The final result (last = 1) appears in the first idle cycle; no stall possible.
// Reset (async, active low) clears the matrix, visited flags and sequencer.
// ----------------------------------------------------------------------------
// dfs_adjacency_matrix_walk_top
// Depth-first walk over a directed graph held as an adjacency bit matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_adjacency_matrix_walk_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  dfsam_pkg::in_t  cmd,
    output logic            busy,
    output logic            strobe,
    output dfsam_pkg::out_t result
);
    import dfsam_pkg::*;

    logic              accept;
    logic              go;
    adj_wr_t           adj_wr;
    logic [NODES-1:0]  adj_row;
    logic [NODE_W-1:0] top_node;

    assign accept = start && !busy;

    assign adj_wr.en   = accept && (cmd.func == FUNC_LOAD)
                         && (32'(cmd.row_index) < NODES);
    assign adj_wr.addr = NODE_W'(cmd.row_index);
    assign adj_wr.bits = NODES'(cmd.row_bits);

    assign go = accept && (cmd.func == FUNC_RUN) && (32'(cmd.start_node) < NODES);

    dfsam_adj u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (adj_wr),
        .rd_addr (top_node),
        .rd_row  (adj_row)
    );

    dfsam_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .go_node  (NODE_W'(cmd.start_node)),
        .adj_row  (adj_row),
        .top_node (top_node),
        .busy     (busy),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ sv/dfsam_check.sv @@
// ----------------------------------------------------------------------------
// dfsam_check
// Port-level checks on the walk block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfs_adjacency_matrix_walk_top_macros.svh"

module dfsam_check (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            start,
    input wire dfsam_pkg::in_t  cmd,
    input wire logic            busy,
    input wire logic            strobe,
    input wire dfsam_pkg::out_t result
);
    import dfsam_pkg::*;

    `DFSAM_ASSERT_IMP(a_mid_beat_busy, clk, rst_n, strobe && !result.last, busy)
    `DFSAM_ASSERT_IMP(a_done_with_last, clk, rst_n, $fell(busy), strobe && result.last)
    `DFSAM_ASSERT_NXT(a_load_silent, clk, rst_n, start && !busy && (cmd.func == FUNC_LOAD), !strobe)
    `DFSAM_ASSERT_NXT(a_run_goes_busy, clk, rst_n, start && !busy && (cmd.func == FUNC_RUN), busy)

endmodule

bind dfs_adjacency_matrix_walk_top dfsam_check u_check (.*);

`default_nettype wire
